// ===== design/sst_pkg.sv =====
package sst_pkg;

  // Table size and derived widths
  localparam int MAX_SLOTS = 32;
  localparam int SLOT_AW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
  localparam int PTR_W     = 6;
  localparam int TICK_W    = 16;

  // Port widths
  localparam int PADDR_W   = 5;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 48;

  // Reset values
  localparam logic [2:0]         BUS_COUNT_RST  = 3'd2;
  localparam logic [9:0]         READ_DELAY_RST = 10'd20;
  localparam logic [7:0]         MAX_ERRORS_RST = 8'd3;
  localparam logic signed [15:0] VALID_LOW_RST  = -16'sd300;
  localparam logic signed [15:0] VALID_HIGH_RST = 16'sd1250;
  localparam logic [15:0]        HELD_RST       = 16'h8000;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_ASSIGN  = 2'd1,
    REQ_READOUT = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    KIND_PUBLISH = 2'd0,
    KIND_CONVERT = 2'd1,
    KIND_READ    = 2'd2,
    KIND_DONE    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_BUS_COUNT  = 3'd0,
    REG_READ_DELAY = 3'd1,
    REG_MAX_ERRORS = 3'd2,
    REG_VALID_LOW  = 3'd3,
    REG_VALID_HIGH = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK_RD,
    ST_WALK_EVAL,
    ST_CONV,
    ST_PTR_EMIT,
    ST_FINISH,
    ST_FLUSH
  } ctrl_state_t;

  typedef struct packed {
    logic [2:0]         bus_count;
    logic [9:0]         read_delay;
    logic [7:0]         max_errors;
    logic signed [15:0] valid_low;
    logic signed [15:0] valid_high;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  rom;
    logic [1:0]  bus;
    logic [7:0]  var_id;
    logic [15:0] held;
    logic [7:0]  errors;
  } slot_entry_t;

  typedef struct packed {
    kind_t       kind;
    logic [4:0]  out_slot;
    logic [7:0]  out_var;
    logic [15:0] value;
    logic        value_valid;
    logic [1:0]  out_bus;
    logic [7:0]  out_rom;
    logic        beep;
    logic        last;
  } result_t;

  typedef struct packed {
    logic accept;
    logic walk_start;
    logic rd_walk;
    logic eval_commit;
    logic emit_conv;
    logic rd_ptr;
    logic emit_read;
    logic finish;
    logic flush;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic walk_needed;
    logic walk_last;
    logic slot_emit;
    logic can_emit;
    logic conv_needed;
    logic read_needed;
    logic pend_valid;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== design/sst_ram.sv =====
module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port that holds when idle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/sst_cfg.sv =====
module sst_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sst_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output sst_pkg::cfg_t               cfg
);

  sst_pkg::reg_idx_t idx;
  logic              wr;

  assign idx    = sst_pkg::reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes during the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bus_count  <= sst_pkg::BUS_COUNT_RST;
      cfg.read_delay <= sst_pkg::READ_DELAY_RST;
      cfg.max_errors <= sst_pkg::MAX_ERRORS_RST;
      cfg.valid_low  <= sst_pkg::VALID_LOW_RST;
      cfg.valid_high <= sst_pkg::VALID_HIGH_RST;
    end else if (wr) begin
      unique case (idx)
        sst_pkg::REG_BUS_COUNT:  cfg.bus_count  <= pwdata[2:0];
        sst_pkg::REG_READ_DELAY: cfg.read_delay <= pwdata[9:0];
        sst_pkg::REG_MAX_ERRORS: cfg.max_errors <= pwdata[7:0];
        sst_pkg::REG_VALID_LOW:  cfg.valid_low  <= pwdata[15:0];
        sst_pkg::REG_VALID_HIGH: cfg.valid_high <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read-back mux; signed limits are sign-extended.
  always_comb begin
    unique case (idx)
      sst_pkg::REG_BUS_COUNT:  prdata = {29'd0, cfg.bus_count};
      sst_pkg::REG_READ_DELAY: prdata = {22'd0, cfg.read_delay};
      sst_pkg::REG_MAX_ERRORS: prdata = {24'd0, cfg.max_errors};
      sst_pkg::REG_VALID_LOW:  prdata = {{16{cfg.valid_low[15]}}, cfg.valid_low};
      sst_pkg::REG_VALID_HIGH: prdata = {{16{cfg.valid_high[15]}}, cfg.valid_high};
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

// ===== design/sst_ctrl.sv =====
module sst_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  sst_pkg::dp_stat_t  stat,
  output sst_pkg::dp_cmd_t   cmd
);

  sst_pkg::ctrl_state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sst_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencing of one tick item: slot walk, convert, read, finish, flush.
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      sst_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          if (stat.is_tick) begin
            if (stat.walk_needed) begin
              cmd.walk_start = 1'b1;
              state_next     = sst_pkg::ST_WALK_RD;
            end else begin
              state_next = sst_pkg::ST_CONV;
            end
          end
        end
      end
      sst_pkg::ST_WALK_RD: begin
        cmd.rd_walk = 1'b1;
        state_next  = sst_pkg::ST_WALK_EVAL;
      end
      sst_pkg::ST_WALK_EVAL: begin
        // The next slot is read while this one is written back.
        if (!stat.slot_emit || stat.can_emit) begin
          cmd.eval_commit = 1'b1;
          if (stat.walk_last) begin
            state_next = sst_pkg::ST_CONV;
          end
        end
      end
      sst_pkg::ST_CONV: begin
        if (!stat.conv_needed || stat.can_emit) begin
          cmd.emit_conv = stat.conv_needed;
          if (stat.read_needed) begin
            cmd.rd_ptr = 1'b1;
            state_next = sst_pkg::ST_PTR_EMIT;
          end else begin
            state_next = sst_pkg::ST_FINISH;
          end
        end
      end
      sst_pkg::ST_PTR_EMIT: begin
        if (stat.can_emit) begin
          cmd.emit_read = 1'b1;
          state_next    = sst_pkg::ST_FINISH;
        end
      end
      sst_pkg::ST_FINISH: begin
        if (stat.can_emit) begin
          cmd.finish = 1'b1;
          state_next = sst_pkg::ST_FLUSH;
        end
      end
      sst_pkg::ST_FLUSH: begin
        if (!stat.pend_valid) begin
          state_next = sst_pkg::ST_IDLE;
        end else if (stat.out_free) begin
          cmd.flush  = 1'b1;
          state_next = sst_pkg::ST_IDLE;
        end
      end
      default: state_next = sst_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== design/sst_dp.sv =====
module sst_dp (
  input  logic              clk,
  input  logic              rst,
  input  sst_pkg::cfg_t     cfg,
  input  sst_pkg::dp_cmd_t  cmd,
  output sst_pkg::dp_stat_t stat,
  input  logic [1:0]        req_type,
  input  logic [4:0]        slot,
  input  logic [15:0]       raw_reading,
  input  logic [7:0]        rom_index,
  input  logic [1:0]        bus_id,
  input  logic [7:0]        var_id,
  input  logic              m_tready,
  output logic              m_valid,
  output sst_pkg::result_t  res
);

  localparam int AW = sst_pkg::SLOT_AW;

  logic [sst_pkg::CNT_W-1:0]  count, idx, idx_inc;
  logic [sst_pkg::PTR_W-1:0]  pointer;
  logic [sst_pkg::TICK_W-1:0] tick_count;
  logic [sst_pkg::MAX_SLOTS-1:0] raw_vld;

  logic                 do_assign, do_readout;
  logic                 slot_we, ram_re;
  logic [AW-1:0]        slot_waddr, ram_raddr;
  sst_pkg::slot_entry_t slot_wdata, slot_q, new_entry, eval_entry;
  logic [15:0]          raw_q;
  logic signed [15:0]   raw_val;
  logic                 in_range, over;
  logic [7:0]           err_inc;
  logic                 ptr_in, done_now;

  sst_pkg::result_t walk_res, conv_res, read_res, done_res, new_res, pend;
  logic             emit_any, pend_valid, out_free, push, push_flush;

  // Item decode for table updates.
  assign do_assign  = cmd.accept && (sst_pkg::req_t'(req_type) == sst_pkg::REQ_ASSIGN) &&
                      (count < sst_pkg::CNT_W'(sst_pkg::MAX_SLOTS));
  assign do_readout = cmd.accept && (sst_pkg::req_t'(req_type) == sst_pkg::REQ_READOUT) &&
                      (32'(slot) < 32'(sst_pkg::MAX_SLOTS));

  assign idx_inc = idx + 1'b1;

  // Slot table and raw reading memories.
  always_comb begin
    new_entry        = '0;
    new_entry.rom    = rom_index;
    new_entry.bus    = bus_id;
    new_entry.var_id = var_id;
    new_entry.held   = sst_pkg::HELD_RST;
  end

  assign slot_we    = do_assign || cmd.eval_commit;
  assign slot_waddr = cmd.eval_commit ? idx[AW-1:0] : count[AW-1:0];
  assign slot_wdata = cmd.eval_commit ? eval_entry : new_entry;
  assign ram_re     = cmd.rd_walk || cmd.rd_ptr || (cmd.eval_commit && !stat.walk_last);
  assign ram_raddr  = cmd.rd_ptr ? pointer[AW-1:0] :
                      (cmd.eval_commit ? idx_inc[AW-1:0] : idx[AW-1:0]);

  sst_ram #(
    .WIDTH($bits(sst_pkg::slot_entry_t)),
    .DEPTH(sst_pkg::MAX_SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (slot_we),
    .waddr(slot_waddr),
    .wdata(slot_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(slot_q)
  );

  sst_ram #(
    .WIDTH(16),
    .DEPTH(sst_pkg::MAX_SLOTS)
  ) u_raw_ram (
    .clk  (clk),
    .we   (do_readout),
    .waddr(AW'(slot)),
    .wdata(raw_reading),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(raw_q)
  );

  // Slot check: an unwritten raw reading counts as zero.
  assign raw_val  = raw_vld[idx[AW-1:0]] ? raw_q : 16'sd0;
  assign in_range = ($signed(raw_val) >= $signed(cfg.valid_low)) &&
                    ($signed(raw_val) <= $signed(cfg.valid_high));
  assign err_inc  = slot_q.errors + 8'd1;
  assign over     = !in_range && (err_inc > cfg.max_errors);

  always_comb begin
    eval_entry = slot_q;
    if (in_range) begin
      eval_entry.held   = raw_val;
      eval_entry.errors = 8'd0;
    end else if (over) begin
      eval_entry.errors = 8'd0;
    end else begin
      eval_entry.errors = err_inc;
    end
  end

  // Candidate results for each kind.
  assign ptr_in   = pointer < sst_pkg::PTR_W'(sst_pkg::MAX_SLOTS);
  assign done_now = pointer >= sst_pkg::PTR_W'(count);

  always_comb begin
    walk_res             = '0;
    walk_res.kind        = sst_pkg::KIND_PUBLISH;
    walk_res.out_slot    = 5'(idx);
    walk_res.out_var     = slot_q.var_id;
    walk_res.value       = in_range ? raw_val : slot_q.held;
    walk_res.value_valid = in_range;
    walk_res.beep        = !in_range;

    conv_res          = '0;
    conv_res.kind     = sst_pkg::KIND_CONVERT;
    conv_res.out_bus  = tick_count[1:0];

    read_res          = '0;
    read_res.kind     = sst_pkg::KIND_READ;
    read_res.out_slot = pointer[4:0];
    read_res.out_bus  = ptr_in ? slot_q.bus : 2'd0;
    read_res.out_rom  = ptr_in ? slot_q.rom : 8'd0;

    done_res      = '0;
    done_res.kind = sst_pkg::KIND_DONE;
  end

  always_comb begin
    priority if (cmd.eval_commit) begin
      new_res = walk_res;
    end else if (cmd.emit_conv) begin
      new_res = conv_res;
    end else if (cmd.emit_read) begin
      new_res = read_res;
    end else begin
      new_res = done_res;
    end
  end

  assign emit_any = (cmd.eval_commit && (in_range || over)) || cmd.emit_conv ||
                    cmd.emit_read || (cmd.finish && done_now);

  // A result waits in the pending stage until the next one shows whether it is last.
  assign out_free   = !m_valid || m_tready;
  assign push_flush = cmd.flush && pend_valid;
  assign push       = (emit_any && pend_valid) || push_flush;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid    <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (push) begin
        m_valid <= 1'b1;
      end else if (m_tready) begin
        m_valid <= 1'b0;
      end
      if (emit_any) begin
        pend_valid <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // The last flag sits in the lowest bit of a result.
  always_ff @(posedge clk) begin
    if (push) begin
      res <= {pend[$bits(sst_pkg::result_t)-1:1], push_flush};
    end
    if (emit_any) begin
      pend <= new_res;
    end
  end

  // Counters and raw valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      idx        <= '0;
      pointer    <= '0;
      tick_count <= '0;
      raw_vld    <= '0;
    end else begin
      if (do_assign) begin
        count <= count + 1'b1;
      end
      if (do_readout) begin
        raw_vld[AW'(slot)] <= 1'b1;
      end
      if (cmd.walk_start) begin
        idx <= '0;
      end else if (cmd.eval_commit) begin
        idx <= idx_inc;
      end
      if (cmd.emit_read) begin
        pointer <= pointer + 1'b1;
      end else if (cmd.finish && done_now) begin
        pointer <= '0;
      end
      if (cmd.finish) begin
        tick_count <= done_now ? '0 : tick_count + 1'b1;
      end
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.is_tick     = sst_pkg::req_t'(req_type) == sst_pkg::REQ_TICK;
    stat.walk_needed = (tick_count == '0) && (count != '0);
    stat.walk_last   = idx_inc == count;
    stat.slot_emit   = in_range || over;
    stat.can_emit    = !pend_valid || out_free;
    stat.conv_needed = tick_count < sst_pkg::TICK_W'(cfg.bus_count);
    stat.read_needed = tick_count > sst_pkg::TICK_W'(cfg.read_delay);
    stat.pend_valid  = pend_valid;
    stat.out_free    = out_free;
  end

endmodule

// ===== design/sensor_scan_validity_tracker_unit.sv =====
// Sensor scan scheduler with validity tracking.
// Requests enter on the s_ stream: tuser holds the request type (tick, assign,
// readout return), tdata the slot, reading and sensor fields. Results leave on
// the m_ stream: tuser holds the result kind, tlast marks the final result of
// one request. Limits and timing are set through the APB port; the user must set
// them only while idle, as the block itself lacks any such check. Assign and
// readout items are handled in the cycle they are accepted, and the block stays
// ready for the next item. A tick at the start of a scan cycle walks the N
// assigned slots through the slot table memory, one slot per cycle while results
// can be passed on; every tick then goes through the convert step, the sensor
// read step when one is due, the finish step and the flush step. Results pass a
// pending stage and an output register; each result waits in the pending stage
// until the next one of its item, or the item's end, is known.
// When the receiver stalls, the walk pauses at the next result and no new item
// is accepted until the final result of the current one is in the output register.
// Reset clears the slot count, tick counter and read pointer, restores the
// default limits and marks every raw reading as zero; it is synchronous.
module sensor_scan_validity_tracker_unit (
  input  logic                          clk,
  input  logic                          rst,
  // s_tdata: slot[4:0], raw_reading[20:5], rom_index[28:21], bus_id[30:29],
  //          var_id[38:31], zero fill
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [sst_pkg::S_TDATA_W-1:0] s_tdata,
  // s_tuser: req_type[1:0]
  input  logic [1:0]                    s_tuser,
  // m_tdata: out_slot[4:0], out_var[12:5], value[28:13], value_valid[29],
  //          out_bus[31:30], out_rom[39:32], beep[40], zero fill
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [sst_pkg::M_TDATA_W-1:0] m_tdata,
  // m_tuser: kind[1:0]
  output logic [1:0]                    m_tuser,
  output logic                          m_tlast,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sst_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  sst_pkg::cfg_t     cfg;
  sst_pkg::dp_cmd_t  cmd;
  sst_pkg::dp_stat_t stat;
  sst_pkg::result_t  res;

  sst_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  sst_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  sst_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .stat       (stat),
    .req_type   (s_tuser),
    .slot       (s_tdata[4:0]),
    .raw_reading(s_tdata[20:5]),
    .rom_index  (s_tdata[28:21]),
    .bus_id     (s_tdata[30:29]),
    .var_id     (s_tdata[38:31]),
    .m_tready   (m_tready),
    .m_valid    (m_tvalid),
    .res        (res)
  );

  // Output packing.
  assign m_tdata = {7'd0, res.beep, res.out_rom, res.out_bus, res.value_valid,
                    res.value, res.out_var, res.out_slot};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

  // An accepted tick always takes the controller out of idle, so s_tready falls.
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == sst_pkg::REQ_TICK) |=> !s_tready)
    else $error("block ready right after a tick item");

  // Table updates finish in the cycle they are accepted.
  a_update_ready: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready &&
    ((s_tuser == sst_pkg::REQ_ASSIGN) || (s_tuser == sst_pkg::REQ_READOUT)) |=> s_tready)
    else $error("block busy after a table update item");

  // No result of a finished item may remain in the pending stage.
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !stat.pend_valid)
    else $error("pending result left behind when idle");

  // The cycle-done marker is always the final result of its item.
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == sst_pkg::KIND_DONE) |-> m_tlast)
    else $error("cycle-done marker without last");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int QUIET_CYCLES = 50;
  localparam int STALL_LIMIT  = 3000;

  logic                          clk;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  // s_tdata: slot[4:0], raw_reading[20:5], rom_index[28:21], bus_id[30:29],
  //          var_id[38:31], zero fill
  logic [sst_pkg::S_TDATA_W-1:0] s_tdata;
  // s_tuser: req_type[1:0]
  logic [1:0]                    s_tuser;
  logic                          m_tvalid;
  logic                          m_tready;
  // m_tdata: out_slot[4:0], out_var[12:5], value[28:13], value_valid[29],
  //          out_bus[31:30], out_rom[39:32], beep[40], zero fill
  logic [sst_pkg::M_TDATA_W-1:0] m_tdata;
  // m_tuser: kind[1:0]
  logic [1:0]                    m_tuser;
  logic                          m_tlast;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [sst_pkg::PADDR_W-1:0]   paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  sensor_scan_validity_tracker_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Shadow copy of the slot table, scan counters and limits.
  sst_pkg::cfg_t cur_cfg;
  logic [7:0]    tbl_rom  [sst_pkg::MAX_SLOTS];
  logic [1:0]    tbl_bus  [sst_pkg::MAX_SLOTS];
  logic [7:0]    tbl_var  [sst_pkg::MAX_SLOTS];
  logic [15:0]   tbl_raw  [sst_pkg::MAX_SLOTS];
  logic [15:0]   tbl_held [sst_pkg::MAX_SLOTS];
  logic [7:0]    tbl_err  [sst_pkg::MAX_SLOTS];
  int            n_assigned;
  logic [15:0]   scan_tick;
  logic [5:0]    scan_ptr;

  // Results still owed by the block, oldest first.
  sst_pkg::result_t pending_results[$];

  int send_idle_pct = 33;
  int recv_idle_pct = 86;
  int n_items;
  int n_results;
  int n_beeps;
  int n_writes;
  int n_fail;
  int stall_cycles;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic string fmt_result(sst_pkg::result_t r);
    return $sformatf({"kind=%0d slot=%0d var=%0d value=%0d valid=%0b ",
                      "bus=%0d rom=%0d beep=%0b last=%0b"},
                     r.kind, r.out_slot, r.out_var, $signed(r.value), r.value_valid,
                     r.out_bus, r.out_rom, r.beep, r.last);
  endfunction

  function automatic void add_result(sst_pkg::kind_t kind, logic [4:0] slot,
                                     logic [7:0] var_id, logic [15:0] value, logic vv,
                                     logic [1:0] bus, logic [7:0] rom, logic beep);
    sst_pkg::result_t r;
    r.kind        = kind;
    r.out_slot    = slot;
    r.out_var     = var_id;
    r.value       = value;
    r.value_valid = vv;
    r.out_bus     = bus;
    r.out_rom     = rom;
    r.beep        = beep;
    r.last        = 1'b0;
    pending_results.push_back(r);
  endfunction

  // Work out what one accepted item does to the table and what it emits.
  function automatic void predict_scan(sst_pkg::req_t req, logic [sst_pkg::S_TDATA_W-1:0] d);
    int               first;
    int               i;
    logic             in_range;
    sst_pkg::result_t r;
    first = pending_results.size();
    case (req)
      sst_pkg::REQ_ASSIGN: begin
        if (n_assigned < sst_pkg::MAX_SLOTS) begin
          tbl_rom[n_assigned]  = d[28:21];
          tbl_bus[n_assigned]  = d[30:29];
          tbl_var[n_assigned]  = d[38:31];
          tbl_held[n_assigned] = sst_pkg::HELD_RST;
          tbl_err[n_assigned]  = 8'd0;
          n_assigned++;
        end
      end
      sst_pkg::REQ_READOUT: begin
        tbl_raw[d[4:0]] = d[20:5];
      end
      sst_pkg::REQ_TICK: begin
        // A tick at the start of a scan cycle checks every assigned slot.
        if (scan_tick == 16'd0) begin
          for (i = 0; i < n_assigned; i++) begin
            in_range = ($signed(tbl_raw[i]) >= $signed(cur_cfg.valid_low)) &&
                       ($signed(tbl_raw[i]) <= $signed(cur_cfg.valid_high));
            tbl_err[i] = tbl_err[i] + 8'd1;
            if (in_range) begin
              tbl_err[i]  = 8'd0;
              tbl_held[i] = tbl_raw[i];
              add_result(sst_pkg::KIND_PUBLISH, 5'(i), tbl_var[i], tbl_held[i], 1'b1,
                         2'd0, 8'd0, 1'b0);
            end
            if (tbl_err[i] > cur_cfg.max_errors) begin
              tbl_err[i] = 8'd0;
              add_result(sst_pkg::KIND_PUBLISH, 5'(i), tbl_var[i], tbl_held[i], 1'b0,
                         2'd0, 8'd0, 1'b1);
            end
          end
        end
        // Convert commands go out on the first ticks; out_bus wraps past three.
        if (scan_tick < cur_cfg.bus_count) begin
          add_result(sst_pkg::KIND_CONVERT, 5'd0, 8'd0, 16'd0, 1'b0, scan_tick[1:0],
                     8'd0, 1'b0);
        end
        if (scan_tick > cur_cfg.read_delay) begin
          add_result(sst_pkg::KIND_READ, scan_ptr[4:0], 8'd0, 16'd0, 1'b0,
                     tbl_bus[scan_ptr], tbl_rom[scan_ptr], 1'b0);
          scan_ptr = scan_ptr + 6'd1;
        end
        scan_tick = scan_tick + 16'd1;
        if (scan_ptr >= n_assigned) begin
          scan_ptr  = 6'd0;
          scan_tick = 16'd0;
          add_result(sst_pkg::KIND_DONE, 5'd0, 8'd0, 16'd0, 1'b0, 2'd0, 8'd0, 1'b0);
        end
      end
      default: begin
      end
    endcase
    // The final result of the item carries the last flag.
    if (pending_results.size() > first) begin
      r = pending_results.pop_back();
      r.last = 1'b1;
      pending_results.push_back(r);
    end
  endfunction

  function automatic void report_fail(string what, string exp_s, string got_s);
    if (n_fail < 10) begin
      $display("%0t: %s", $time, what);
      $display("  expected %s", exp_s);
      $display("  actual   %s", got_s);
    end
    n_fail++;
  endfunction

  // Compare each result taken from the block with the oldest one owed.
  always @(posedge clk) begin
    sst_pkg::result_t got;
    sst_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.kind        = sst_pkg::kind_t'(m_tuser);
      got.out_slot    = m_tdata[4:0];
      got.out_var     = m_tdata[12:5];
      got.value       = m_tdata[28:13];
      got.value_valid = m_tdata[29];
      got.out_bus     = m_tdata[31:30];
      got.out_rom     = m_tdata[39:32];
      got.beep        = m_tdata[40];
      got.last        = m_tlast;
      n_results++;
      if (got.beep) n_beeps++;
      if (pending_results.size() == 0) begin
        report_fail("result with nothing owed", "none", fmt_result(got));
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.out_slot !== want.out_slot ||
            got.out_var !== want.out_var || got.value !== want.value ||
            got.value_valid !== want.value_valid || got.out_bus !== want.out_bus ||
            got.out_rom !== want.out_rom || got.beep !== want.beep ||
            got.last !== want.last) begin
          report_fail("result mismatch", fmt_result(want), fmt_result(got));
        end
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles in which no item moves on either stream.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("No item moved for %0d cycles; %0d results still owed.",
               STALL_LIMIT, pending_results.size());
      $display("tb_top: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [sst_pkg::S_TDATA_W-1:0] make_data(logic [4:0] slot,
                                                              logic [15:0] raw,
                                                              logic [7:0] rom,
                                                              logic [1:0] bus,
                                                              logic [7:0] var_id);
    return {1'b0, var_id, bus, rom, raw, slot};
  endfunction

  function automatic logic [sst_pkg::S_TDATA_W-1:0] rand_data();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return {1'b0, r[38:0]};
  endfunction

  // Readings cluster on the edges of the accepted range.
  function automatic logic [15:0] pick_reading();
    case ($urandom_range(5))
      0:       return cur_cfg.valid_low;
      1:       return cur_cfg.valid_high;
      2:       return cur_cfg.valid_low - 16'd1;
      3:       return cur_cfg.valid_high + 16'd1;
      4:       return 16'($urandom);
      default: return 16'($urandom_range(1700)) - 16'd400;
    endcase
  endfunction

  // Present one item, with random gaps before it, and hold it until taken.
  task automatic send_item(sst_pkg::req_t req, logic [sst_pkg::S_TDATA_W-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= req;
    do @(posedge clk); while (!s_tready);
    predict_scan(req, d);
    n_items++;
  endtask

  // Let the block drain and settle before anything is reconfigured.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(sst_pkg::reg_idx_t idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      sst_pkg::REG_BUS_COUNT:  cur_cfg.bus_count  = val[2:0];
      sst_pkg::REG_READ_DELAY: cur_cfg.read_delay = val[9:0];
      sst_pkg::REG_MAX_ERRORS: cur_cfg.max_errors = val[7:0];
      sst_pkg::REG_VALID_LOW:  cur_cfg.valid_low  = val[15:0];
      sst_pkg::REG_VALID_HIGH: cur_cfg.valid_high = val[15:0];
      default: begin
      end
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    n_writes++;
  endtask

  task automatic set_config(logic [2:0] bus_count, logic [9:0] read_delay,
                            logic [7:0] max_errors, logic [15:0] lo, logic [15:0] hi);
    wait_idle();
    write_reg(sst_pkg::REG_BUS_COUNT, {29'd0, bus_count});
    write_reg(sst_pkg::REG_READ_DELAY, {22'd0, read_delay});
    write_reg(sst_pkg::REG_MAX_ERRORS, {24'd0, max_errors});
    write_reg(sst_pkg::REG_VALID_LOW, {16'd0, lo});
    write_reg(sst_pkg::REG_VALID_HIGH, {16'd0, hi});
  endtask

  // Mostly sane limits, sometimes an arbitrary or inverted range.
  task automatic random_config();
    logic [15:0] lo;
    logic [15:0] hi;
    if ($urandom_range(3) == 0) begin
      lo = 16'($urandom);
      hi = 16'($urandom);
    end else begin
      lo = 16'($urandom_range(600)) - 16'd500;
      hi = lo + 16'($urandom_range(1500));
    end
    set_config(3'($urandom_range(7)), 10'($urandom_range(3)), 8'($urandom_range(3)), lo, hi);
  endtask

  // One random item: mostly ticks and readouts aimed at assigned slots.
  task automatic random_item(int assign_pct);
    logic [sst_pkg::S_TDATA_W-1:0] d;
    int                            pick;
    d    = rand_data();
    pick = $urandom_range(99);
    if (pick < 5) begin
      send_item(sst_pkg::REQ_NONE, d);
    end else if (pick < 5 + assign_pct) begin
      send_item(sst_pkg::REQ_ASSIGN, d);
    end else if (pick < 35 + assign_pct) begin
      if (n_assigned > 0 && $urandom_range(3) != 0) d[4:0] = 5'($urandom_range(n_assigned - 1));
      if ($urandom_range(9) < 7) d[20:5] = pick_reading();
      send_item(sst_pkg::REQ_READOUT, d);
    end else begin
      send_item(sst_pkg::REQ_TICK, d);
    end
  endtask

  // Ticks with an empty table, an unknown request and a stray readout.
  task automatic test_empty_table();
    send_item(sst_pkg::REQ_TICK, '0);
    send_item(sst_pkg::REQ_NONE, {1'b0, {(sst_pkg::S_TDATA_W-1){1'b1}}});
    send_item(sst_pkg::REQ_READOUT, make_data(5'd31, 16'h8000, 8'd0, 2'd0, 8'd0));
    send_item(sst_pkg::REQ_TICK, {1'b0, {(sst_pkg::S_TDATA_W-1){1'b1}}});
  endtask

  // Three slots through one full scan cycle and a second walk.
  task automatic test_directed_walk();
    set_config(3'd7, 10'd2, 8'd0, sst_pkg::VALID_LOW_RST, sst_pkg::VALID_HIGH_RST);
    send_item(sst_pkg::REQ_ASSIGN, make_data(5'd0, 16'd0, 8'h00, 2'd0, 8'h00));
    send_item(sst_pkg::REQ_ASSIGN, make_data(5'd0, 16'd0, 8'hFF, 2'd3, 8'hFF));
    send_item(sst_pkg::REQ_ASSIGN, make_data(5'd0, 16'd0, 8'h5A, 2'd1, 8'hA5));
    // Readings on both range edges and one just above.
    send_item(sst_pkg::REQ_READOUT,
              make_data(5'd0, sst_pkg::VALID_LOW_RST, 8'd0, 2'd0, 8'd0));
    send_item(sst_pkg::REQ_READOUT,
              make_data(5'd1, sst_pkg::VALID_HIGH_RST, 8'd0, 2'd0, 8'd0));
    send_item(sst_pkg::REQ_READOUT, make_data(5'd2, 16'sd1251, 8'd0, 2'd0, 8'd0));
    repeat (6) send_item(sst_pkg::REQ_TICK, '0);
    // Out-of-range readings invalidate held values on the next walk.
    send_item(sst_pkg::REQ_READOUT, make_data(5'd0, 16'h8000, 8'd0, 2'd0, 8'd0));
    send_item(sst_pkg::REQ_READOUT, make_data(5'd1, 16'h7FFF, 8'd0, 2'd0, 8'd0));
    send_item(sst_pkg::REQ_READOUT, make_data(5'd2, -16'sd301, 8'd0, 2'd0, 8'd0));
    send_item(sst_pkg::REQ_TICK, '0);
  endtask

  task automatic test_random_small();
    random_config();
    repeat (40) random_item(8);
  endtask

  // Widest limits, then an inverted range with no read delay.
  task automatic test_limits();
    set_config(3'd0, 10'd1023, 8'd255, 16'h8000, 16'h7FFF);
    repeat (8) send_item(sst_pkg::REQ_TICK, rand_data());
    set_config(3'd4, 10'd0, 8'd1, 16'sd100, -16'sd100);
    repeat (30) send_item(sst_pkg::REQ_TICK, rand_data());
  endtask

  // Fill the table and try two assigns beyond it.
  task automatic test_fill_table();
    int n;
    n = sst_pkg::MAX_SLOTS + 2 - n_assigned;
    repeat (n) send_item(sst_pkg::REQ_ASSIGN, rand_data());
  endtask

  task automatic test_random_full();
    random_config();
    repeat (45) random_item(3);
  endtask

  initial begin
    int i;
    cur_cfg = {sst_pkg::BUS_COUNT_RST, sst_pkg::READ_DELAY_RST, sst_pkg::MAX_ERRORS_RST,
               sst_pkg::VALID_LOW_RST, sst_pkg::VALID_HIGH_RST};
    for (i = 0; i < sst_pkg::MAX_SLOTS; i++) begin
      tbl_rom[i]  = 8'd0;
      tbl_bus[i]  = 2'd0;
      tbl_var[i]  = 8'd0;
      tbl_raw[i]  = 16'd0;
      tbl_held[i] = sst_pkg::HELD_RST;
      tbl_err[i]  = 8'd0;
    end
    n_assigned = 0;
    scan_tick  = 16'd0;
    scan_ptr   = 6'd0;

    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= sst_pkg::REQ_TICK;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_directed_walk();
    test_random_small();
    test_limits();

    // Swap the stall mix, then run without any idling.
    send_idle_pct = 86;
    recv_idle_pct = 33;
    test_fill_table();
    test_random_full();
    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_full();
    wait_idle();

    $display("Covered %0d items over %0d assigned slots and %0d register writes.",
             n_items, n_assigned, n_writes);
    $display("Checked %0d results, %0d of them invalidations with a beep; %0d failures.",
             n_results, n_beeps, n_fail);
    if (n_fail == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/sst_pkg.sv
design/sst_ram.sv
design/sst_cfg.sv
design/sst_ctrl.sv
design/sst_dp.sv
design/sensor_scan_validity_tracker_unit.sv
tb/sv/tb_top.sv
